// ----- rtl/ratio_to_mult_shift_defines.svh -----
// Assertion macros for the ratio_to_mult_shift block.
// Needs signals named clk and rst in the scope of use.
`ifndef RATIO_TO_MULT_SHIFT_DEFINES_SVH
`define RATIO_TO_MULT_SHIFT_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define RTMS_ASSERT_NOW(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RTMS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/rtms_pkg.sv -----
// Shared types, constants and helpers for the ratio_to_mult_shift block.
// No dependencies; compile first after the defines header.
package rtms_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned SHIFT_W         = 6;
  localparam int unsigned LZ_W            = $clog2(DATA_W);
  localparam int unsigned STEPS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES      = DATA_W / STEPS_PER_STAGE;

  // Shift reported for a zero numerator.
  localparam logic [SHIFT_W-1:0] ZERO_NUM_SHIFT = SHIFT_W'(DATA_W);

  typedef logic [DATA_W-1:0] word_t;

  // Per-stage state of the division pipeline.
  typedef struct packed {
    word_t               rem;      // partial remainder, below dvs
    word_t               low;      // dividend bits still to shift in
    word_t               quo;      // quotient bits so far
    word_t               dvs;      // normalized divisor
    logic [SHIFT_W-1:0]  shift;
    logic                num_zero;
    logic                den_zero;
  } div_state_t;

  // Count leading zeros; a zero word gives zero (handled as a special case).
  function automatic logic [LZ_W-1:0] lead_zeros(word_t v);
    logic [LZ_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (v[i]) begin
        cnt = LZ_W'(DATA_W - 1 - i);
      end
    end
    return cnt;
  endfunction

endpackage

// ----- rtl/rtms_in_if.sv -----
// Request channel of ratio_to_mult_shift: valid/ready plus the ratio.
// Depends on rtms_pkg.
interface rtms_in_if import rtms_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t numerator;
  word_t denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

// ----- rtl/rtms_out_if.sv -----
// Result channel of ratio_to_mult_shift: valid/ready plus multiplier and shift.
// Depends on rtms_pkg.
interface rtms_out_if import rtms_pkg::*; ();
  logic               valid;
  logic               ready;
  word_t              multiplier;
  logic [SHIFT_W-1:0] shift_amount;
  logic               div_error;

  modport source (output valid, output multiplier, output shift_amount, output div_error,
                  input ready);
  modport sink   (input valid, input multiplier, input shift_amount, input div_error,
                  output ready);
endinterface

// ----- rtl/ratio_to_mult_shift.sv -----
// ratio_to_mult_shift top level: ratio to normalized multiplier and right shift.
// Depends on rtms_pkg, rtms_in_if, rtms_out_if and ratio_to_mult_shift_defines.svh.

// Converts numerator/denominator into a 32-bit multiplier with its top bit set
// and a right shift of 0 to 63, so that (x * multiplier) >> shift_amount comes
// close to x * numerator / denominator. The multiplier is the quotient
// floor(numerator * 2^shift / denominator), chosen to land in [2^31, 2^32), and
// is rounded up by one when a remainder is left (a quotient of all ones then
// wraps to zero). A zero numerator gives multiplier 0 and shift 32; a zero
// denominator sets div_error with both other fields zero. The block is a fully
// pipelined restoring divider: one request is taken every clock cycle unless
// the result channel stalls, and each request passes through one stage for
// the leading-zero count, one for normalization, eight division stages of
// four quotient bits each and one for round-up. Backpressure on the result
// channel freezes the whole pipeline; nothing is dropped or repeated.
`include "ratio_to_mult_shift_defines.svh"

module ratio_to_mult_shift import rtms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rtms_in_if.sink    ratio,
  rtms_out_if.source result
);

  // Global advance: move every stage when the output slot is free or drained.
  logic adv;

  // Stage A: captured operands and their leading-zero counts.
  logic             a_vld;
  word_t            a_num;
  word_t            a_den;
  logic [LZ_W-1:0]  a_lzn;
  logic [LZ_W-1:0]  a_lzd;

  // Division pipeline: entry 0 is the normalized start state.
  logic [DIV_STAGES:0] div_vld;
  div_state_t          st [DIV_STAGES+1];

  // Output register.
  logic               out_vld;
  word_t              out_mult;
  logic [SHIFT_W-1:0] out_shift;
  logic               out_err;

  assign adv         = !out_vld || result.ready;
  assign ratio.ready = adv;

  // ---- Stage A: count leading zeros of both operands ----
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= ratio.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_num <= ratio.numerator;
      a_den <= ratio.denominator;
      a_lzn <= lead_zeros(ratio.numerator);
      a_lzd <= lead_zeros(ratio.denominator);
    end
  end

  // ---- Stage B: normalize and set up the 64-by-32 division ----
  // With N and D both normalized, N/D lies in (1/2, 2). Take the dividend as
  // N * 2^31 when N >= D, else N * 2^32, so the quotient fills 32 bits and
  // the upper dividend word stays below D.
  word_t               b_nnum;
  word_t               b_nden;
  logic                b_ge;
  logic [SHIFT_W:0]    b_base;
  div_state_t          b_state;

  always_comb begin
    b_nnum = a_num << a_lzn;
    b_nden = a_den << a_lzd;
    b_ge   = (b_nnum >= b_nden);
    b_base = b_ge ? (SHIFT_W+1)'(DATA_W - 1) : (SHIFT_W+1)'(DATA_W);

    b_state.rem      = b_ge ? {1'b0, b_nnum[DATA_W-1:1]} : b_nnum;
    b_state.low      = b_ge ? {b_nnum[0], {(DATA_W-1){1'b0}}} : '0;
    b_state.quo      = '0;
    b_state.dvs      = b_nden;
    b_state.shift    = SHIFT_W'(b_base + (SHIFT_W+1)'(a_lzn) - (SHIFT_W+1)'(a_lzd));
    b_state.num_zero = (a_num == '0);
    b_state.den_zero = (a_den == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld[0] <= 1'b0;
    end else if (adv) begin
      div_vld[0] <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= b_state;
    end
  end

  // ---- Division stages: four restoring steps each ----
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    div_state_t nxt;

    always_comb begin
      logic [DATA_W:0] trial;
      nxt = st[j];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        // Bring down the next dividend bit, subtract the divisor if it fits.
        trial   = {nxt.rem, nxt.low[DATA_W-1]};
        nxt.low = nxt.low << 1;
        if (trial >= {1'b0, nxt.dvs}) begin
          trial   = trial - {1'b0, nxt.dvs};
          nxt.quo = {nxt.quo[DATA_W-2:0], 1'b1};
        end else begin
          nxt.quo = {nxt.quo[DATA_W-2:0], 1'b0};
        end
        nxt.rem = trial[DATA_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_vld[j+1] <= 1'b0;
      end else if (adv) begin
        div_vld[j+1] <= div_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[j+1] <= nxt;
      end
    end
  end

  // ---- Output stage: round up and apply the special cases ----
  div_state_t         fin;
  word_t              fin_mult;
  logic [SHIFT_W-1:0] fin_shift;

  always_comb begin
    fin = st[DIV_STAGES];
    // Round up on any remainder; wraps to zero on an all-ones quotient.
    fin_mult  = fin.quo + DATA_W'(fin.rem != '0);
    fin_shift = fin.shift;
    if (fin.den_zero) begin
      fin_mult  = '0;
      fin_shift = '0;
    end else if (fin.num_zero) begin
      fin_mult  = '0;
      fin_shift = ZERO_NUM_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= div_vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mult  <= fin_mult;
      out_shift <= fin_shift;
      out_err   <= fin.den_zero;
    end
  end

  assign result.valid        = out_vld;
  assign result.multiplier   = out_mult;
  assign result.shift_amount = out_shift;
  assign result.div_error    = out_err;

  // ---- Assertions ----
  `RTMS_ASSERT_IMP(a_start_rem_below_dvs, div_vld[0] && !st[0].den_zero, st[0].rem < st[0].dvs, "division start remainder not below divisor")
  `RTMS_ASSERT_IMP(a_quo_normalized, div_vld[DIV_STAGES] && !st[DIV_STAGES].den_zero && !st[DIV_STAGES].num_zero, st[DIV_STAGES].quo[DATA_W-1], "final quotient not normalized")
  `RTMS_ASSERT_IMP(a_err_zero_fields, result.valid && result.div_error, result.multiplier == '0 && result.shift_amount == '0, "error result carries nonzero fields")
  `RTMS_ASSERT_IMP(a_mult_top_bit, result.valid && !result.div_error && result.multiplier != '0, result.multiplier[DATA_W-1], "nonzero multiplier missing top bit")

endmodule

// ----- test/rtms_checker.sv -----
// Result checker for ratio_to_mult_shift: predicts each conversion and compares it.
// Depends on rtms_pkg, rtms_in_if and rtms_out_if; instantiated by tb.
module rtms_checker import rtms_pkg::*; (
  input  logic clk,
  input  logic rst,
  rtms_in_if   ratio,
  rtms_out_if  result,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    word_t              num;
    word_t              den;
    word_t              mult;
    logic [SHIFT_W-1:0] shift;
    logic               err;
  } conversion_t;

  conversion_t conversions_due[$];
  int          mismatches = 0;

  // Long division, one quotient bit per step, until the quotient is normalized.
  function automatic conversion_t predict_mult_shift(word_t num, word_t den);
    conversion_t conv;
    word_t       quo;
    word_t       sel;
    logic [63:0] rem;
    int          top;
    int          whole_bits;
    conv     = '0;
    conv.num = num;
    conv.den = den;
    if (den == '0) begin
      conv.err = 1'b1;
      return conv;
    end
    if (num == '0) begin
      conv.shift = SHIFT_W'(DATA_W);
      return conv;
    end
    top = 0;
    for (int b = 0; b < DATA_W; b++) begin
      if (num[b]) top = b;
    end
    whole_bits = top + 1;
    sel        = word_t'(1) << top;
    quo        = '0;
    rem        = '0;
    for (int k = 0; k < 64 + top && !quo[DATA_W-1]; k++) begin
      rem = {rem[62:0], |(num & sel)};
      quo = quo << 1;
      sel = sel >> 1;
      if (rem >= {32'b0, den}) begin
        rem    = rem - {32'b0, den};
        quo[0] = 1'b1;
      end
      if (quo == '0) whole_bits--;
    end
    // Round up; an all-ones quotient wraps to zero.
    if (rem != '0) quo = quo + 1'b1;
    conv.mult  = quo;
    conv.shift = SHIFT_W'(DATA_W - whole_bits);
    return conv;
  endfunction

  always @(posedge clk) begin : watch
    conversion_t head;
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (conversions_due.size() == 0) begin
          mismatches++;
          $error("result with no request outstanding: multiplier %h shift %0d error %b",
                 result.multiplier, result.shift_amount, result.div_error);
        end else begin
          head = conversions_due.pop_front();
          if (result.multiplier !== head.mult) begin
            mismatches++;
            $error("multiplier (%h/%h): expected %h, got %h",
                   head.num, head.den, head.mult, result.multiplier);
          end
          if (result.shift_amount !== head.shift) begin
            mismatches++;
            $error("shift_amount (%h/%h): expected %0d, got %0d",
                   head.num, head.den, head.shift, result.shift_amount);
          end
          if (result.div_error !== head.err) begin
            mismatches++;
            $error("div_error (%h/%h): expected %b, got %b",
                   head.num, head.den, head.err, result.div_error);
          end
        end
      end
      if (ratio.valid && ratio.ready) begin
        conversions_due.push_back(predict_mult_shift(ratio.numerator, ratio.denominator));
      end
    end
    fail_count <= mismatches;
    pending    <= conversions_due.size();
  end

endmodule

// ----- test/tb.sv -----
// Top-level regression for ratio_to_mult_shift: clock, reset, requests and verdict.
// Depends on rtms_pkg, rtms_in_if, rtms_out_if, ratio_to_mult_shift and rtms_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtms_pkg::*;

  localparam int RANDOM_REQUESTS = 900;
  localparam int CYCLE_LIMIT     = 100000;
  // Pipeline is 11 deep; give the tail some margin.
  localparam int DRAIN_CYCLES    = 30;
  localparam int HOLD_CYCLES     = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   fail_count;
  int   pending;

  rtms_in_if  ratio_ch ();
  rtms_out_if result_ch ();

  ratio_to_mult_shift dut (
    .clk    (clk),
    .rst    (rst),
    .ratio  (ratio_ch),
    .result (result_ch)
  );

  rtms_checker conv_check (
    .clk        (clk),
    .rst        (rst),
    .ratio      (ratio_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // Watchdog: a stuck handshake or a lost result ends the run here.
  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("ratio_to_mult_shift regression: fail");
    $finish;
  end

  // Draw a word biased toward a wide spread of magnitudes, with some zeros
  // and all-ones mixed in.
  function automatic word_t draw_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return '0;
    if (pick < 6) return '1;
    if (pick < 40) return word_t'($urandom());
    return word_t'($urandom()) >> $urandom_range(0, 31);
  endfunction

  // Offer one request after a random gap and hold it until accepted. Keep
  // valid high across back-to-back requests; drop it only ahead of a gap.
  task automatic send_ratio(input word_t num, input word_t den, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      ratio_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ratio_ch.valid       <= 1'b1;
    ratio_ch.numerator   <= num;
    ratio_ch.denominator <= den;
    do @(posedge clk); while (!ratio_ch.ready);
  endtask

  // Stop offering and hold until every outstanding conversion has come back.
  // The checker's count is registered, so wait for a clock edge before looking at it.
  task automatic wait_until_drained();
    ratio_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Request side: reset, directed corner cases, then random ratios.
  initial begin : stimulus
    word_t base_n;
    word_t base_d;
    word_t scale;
    bit    burst;
    ratio_ch.valid       <= 1'b0;
    ratio_ch.numerator   <= '0;
    ratio_ch.denominator <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Zero denominator, with zero and full numerators.
    send_ratio(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_ratio(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    // Zero numerator.
    send_ratio(32'h0000_0000, 32'h0000_0001, 1'b0);
    send_ratio(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    // Extremes of the ratio: shift at its floor and near its ceiling.
    send_ratio(32'h0000_0001, 32'h0000_0001, 1'b0);
    send_ratio(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    send_ratio(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
    send_ratio(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_ratio(32'h8000_0000, 32'h0000_0001, 1'b0);
    send_ratio(32'h0000_0001, 32'h8000_0000, 1'b0);
    // All-ones quotient, exact and just short of it (closest to round-up wrap).
    send_ratio(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    send_ratio(32'hFFFF_FFFF, 32'h8000_0001, 1'b0);
    send_ratio(32'hFFFF_FFFE, 32'h7FFF_FFFF, 1'b0);
    // Remainder left over: round up.
    send_ratio(32'h0000_0002, 32'h0000_0003, 1'b0);
    send_ratio(32'h0000_0001, 32'h0000_0003, 1'b0);
    send_ratio(32'h0000_3039, 32'h0FFF_FFFF, 1'b0);
    // Alternating bit patterns.
    send_ratio(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_ratio(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    // Same ratio, reduced and unreduced.
    send_ratio(32'h0000_0001, 32'h0000_0002, 1'b0);
    send_ratio(32'h0000_0003, 32'h0000_0006, 1'b0);
    send_ratio(32'h0000_0003, 32'h0000_0002, 1'b0);
    send_ratio(32'h0000_0006, 32'h0000_0004, 1'b0);
    send_ratio(32'h0000_0007, 32'h0000_0007, 1'b0);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      // Halfway through, let the pipeline run dry before going on.
      if (i == RANDOM_REQUESTS / 2) wait_until_drained();
      // Every so often, offer a stretch of requests back to back.
      burst = (i % 150) >= 120;
      if ($urandom_range(0, 9) == 0) begin
        // Scaled copy of a small ratio; it must convert like the reduced one.
        base_n = $urandom_range(1, 65535);
        base_d = $urandom_range(1, 65535);
        scale  = $urandom_range(1, 65535);
        send_ratio(base_n * scale, base_d * scale, burst);
      end else begin
        send_ratio(draw_word(), draw_word(), burst);
      end
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ratio_to_mult_shift regression: pass");
    end else begin
      $display("ratio_to_mult_shift regression: fail");
    end
    $finish;
  end

  // Result side: random stalls per result, stretches with ready held high,
  // and two long hold-offs so the pipeline fills and pushes back on requests.
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    result_ch.ready <= 1'b0;
    wait (!rst);
    forever begin
      if (taken == 250 || taken == 700) begin
        stall = HOLD_CYCLES;
      end else if ((taken % 170) >= 130) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 4);
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      taken++;
    end
  end

endmodule
